[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the list engine modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ordered list engine check failed");
`define OLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list engine sequencing check failed");
`else
`define OLE_ASSERT(lbl, clk, rst, prop)
`define OLE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/ole_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered list engine package
// Command and status codes, controller states, and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam logic [2:0] CMD_INS_HEAD   = 3'd0;
  localparam logic [2:0] CMD_INS_TAIL   = 3'd1;
  localparam logic [2:0] CMD_INS_AFTER  = 3'd2;
  localparam logic [2:0] CMD_INS_BEFORE = 3'd3;
  localparam logic [2:0] CMD_DEL_HEAD   = 3'd4;
  localparam logic [2:0] CMD_DEL_TAIL   = 3'd5;
  localparam logic [2:0] CMD_DEL_AFTER  = 3'd6;
  localparam logic [2:0] CMD_DEL_BEFORE = 3'd7;

  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_EMPTY = 3'd1;
  localparam logic [2:0] STS_NOKEY = 3'd2;
  localparam logic [2:0] STS_NONB  = 3'd3;
  localparam logic [2:0] STS_FULL  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEEK,
    ST_WALK,
    ST_ALLOC,
    ST_TAKE,
    ST_LINK1,
    ST_LINK2,
    ST_UNLINK_RD,
    ST_UNLINK1,
    ST_UNLINK2,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DISPATCH,
    OP_SEEK,
    OP_WALK,
    OP_ALLOC,
    OP_TAKE,
    OP_LINK1,
    OP_LINK2,
    OP_UNLINK_RD,
    OP_UNLINK1,
    OP_UNLINK2
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       head_nil;
    logic       free_nil;
    logic       match;
    logic       next_nil;
    logic       prev_nil;
  } sts_t;

endpackage

[rtl/ole_ctrl.sv]
// ----------------------------------------------------------------------------
// Ordered list engine controller
// Sequences each command through search, allocation, linking and unlinking
// steps and decides the returned status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ole_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output logic [2:0]    status,
  output ole_pkg::ctl_t ctl,
  input  ole_pkg::sts_t sts
);

  ole_pkg::state_t state, state_next;
  logic [2:0] status_q, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ole_pkg::ST_IDLE;
      status_q <= ole_pkg::STS_OK;
    end else begin
      state    <= state_next;
      status_q <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    status_next = status_q;
    case (state)
      ole_pkg::ST_IDLE, ole_pkg::ST_DONE: begin
        state_next = start ? ole_pkg::ST_DISPATCH : ole_pkg::ST_IDLE;
      end
      ole_pkg::ST_DISPATCH: begin
        case (sts.cmd)
          ole_pkg::CMD_INS_HEAD, ole_pkg::CMD_INS_TAIL: begin
            if (sts.free_nil) begin
              state_next  = ole_pkg::ST_DONE;
              status_next = ole_pkg::STS_FULL;
            end else begin
              state_next = ole_pkg::ST_ALLOC;
            end
          end
          ole_pkg::CMD_INS_AFTER: begin
            if (sts.head_nil) begin
              state_next  = ole_pkg::ST_DONE;
              status_next = ole_pkg::STS_EMPTY;
            end else begin
              state_next = ole_pkg::ST_SEEK;
            end
          end
          ole_pkg::CMD_DEL_HEAD, ole_pkg::CMD_DEL_TAIL: begin
            if (sts.head_nil) begin
              state_next  = ole_pkg::ST_DONE;
              status_next = ole_pkg::STS_EMPTY;
            end else begin
              state_next = ole_pkg::ST_UNLINK_RD;
            end
          end
          default: begin
            // Insert before and the keyed deletes report a missing key on
            // an empty list.
            if (sts.head_nil) begin
              state_next  = ole_pkg::ST_DONE;
              status_next = ole_pkg::STS_NOKEY;
            end else begin
              state_next = ole_pkg::ST_SEEK;
            end
          end
        endcase
      end
      ole_pkg::ST_SEEK: begin
        state_next = ole_pkg::ST_WALK;
      end
      ole_pkg::ST_WALK: begin
        if (sts.match) begin
          case (sts.cmd)
            ole_pkg::CMD_DEL_AFTER: begin
              if (sts.next_nil) begin
                state_next  = ole_pkg::ST_DONE;
                status_next = ole_pkg::STS_NONB;
              end else begin
                state_next = ole_pkg::ST_UNLINK_RD;
              end
            end
            ole_pkg::CMD_DEL_BEFORE: begin
              if (sts.prev_nil) begin
                state_next  = ole_pkg::ST_DONE;
                status_next = ole_pkg::STS_NONB;
              end else begin
                state_next = ole_pkg::ST_UNLINK_RD;
              end
            end
            default: begin
              if (sts.free_nil) begin
                state_next  = ole_pkg::ST_DONE;
                status_next = ole_pkg::STS_FULL;
              end else begin
                state_next = ole_pkg::ST_ALLOC;
              end
            end
          endcase
        end else if (sts.next_nil) begin
          state_next  = ole_pkg::ST_DONE;
          status_next = ole_pkg::STS_NOKEY;
        end
      end
      ole_pkg::ST_ALLOC: begin
        state_next = ole_pkg::ST_TAKE;
      end
      ole_pkg::ST_TAKE: begin
        state_next = ole_pkg::ST_LINK1;
      end
      ole_pkg::ST_LINK1: begin
        if (sts.head_nil) begin
          state_next  = ole_pkg::ST_DONE;
          status_next = ole_pkg::STS_OK;
        end else begin
          state_next = ole_pkg::ST_LINK2;
        end
      end
      ole_pkg::ST_LINK2: begin
        state_next  = ole_pkg::ST_DONE;
        status_next = ole_pkg::STS_OK;
      end
      ole_pkg::ST_UNLINK_RD: begin
        state_next = ole_pkg::ST_UNLINK1;
      end
      ole_pkg::ST_UNLINK1: begin
        state_next = ole_pkg::ST_UNLINK2;
      end
      ole_pkg::ST_UNLINK2: begin
        state_next  = ole_pkg::ST_DONE;
        status_next = ole_pkg::STS_OK;
      end
      default: begin
        state_next = ole_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.op = ole_pkg::OP_NONE;
    busy   = 1'b1;
    done   = 1'b0;
    case (state)
      ole_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) ctl.op = ole_pkg::OP_CAPTURE;
      end
      ole_pkg::ST_DONE: begin
        busy = 1'b0;
        done = 1'b1;
        if (start) ctl.op = ole_pkg::OP_CAPTURE;
      end
      ole_pkg::ST_DISPATCH:  ctl.op = ole_pkg::OP_DISPATCH;
      ole_pkg::ST_SEEK:      ctl.op = ole_pkg::OP_SEEK;
      ole_pkg::ST_WALK:      ctl.op = ole_pkg::OP_WALK;
      ole_pkg::ST_ALLOC:     ctl.op = ole_pkg::OP_ALLOC;
      ole_pkg::ST_TAKE:      ctl.op = ole_pkg::OP_TAKE;
      ole_pkg::ST_LINK1:     ctl.op = ole_pkg::OP_LINK1;
      ole_pkg::ST_LINK2:     ctl.op = ole_pkg::OP_LINK2;
      ole_pkg::ST_UNLINK_RD: ctl.op = ole_pkg::OP_UNLINK_RD;
      ole_pkg::ST_UNLINK1:   ctl.op = ole_pkg::OP_UNLINK1;
      ole_pkg::ST_UNLINK2:   ctl.op = ole_pkg::OP_UNLINK2;
      default:               ctl.op = ole_pkg::OP_NONE;
    endcase
  end

  assign status = status_q;

  `OLE_ASSERT_NEXT(a_accept_dispatch, clk, rst, start && !busy, state == ole_pkg::ST_DISPATCH)
  `OLE_ASSERT(a_done_not_busy, clk, rst, done |-> !busy)

endmodule

[rtl/ole_dpath.sv]
// ----------------------------------------------------------------------------
// Ordered list engine datapath
// Node memories, list pointers, free list and element count, driven one
// step at a time by the controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ole_dpath #(
  parameter int CAPACITY   = 256,
  parameter int WORD_WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  ole_pkg::ctl_t ctl,
  output ole_pkg::sts_t sts,
  input  logic [2:0]    command,
  input  logic [63:0]   key,
  input  logic [63:0]   value,
  output logic [8:0]    count
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  logic [WORD_WIDTH-1:0] word_mem [CAPACITY];
  logic [IW-1:0]         next_mem [CAPACITY];
  logic [IW-1:0]         prev_mem [CAPACITY];

  logic [WORD_WIDTH-1:0] rd_word;
  logic [IW-1:0]         rd_next, rd_prev;

  logic [2:0]            cmd_q;
  logic [WORD_WIDTH-1:0] key_q, value_q;
  logic [IW-1:0]         cur, m_idx, n_idx, nb_idx;
  logic [IW-1:0]         head, tail, free_idx, hwm, elem_count;
  logic [IW-1:0]         cur_next, m_next, n_next, nb_next;
  logic [IW-1:0]         head_next, tail_next, free_next, hwm_next, count_next;

  logic [IW-1:0]         rd_idx;
  logic                  word_we, next_we, prev_we;
  logic [IW-1:0]         word_wa, next_wa, next_wd, prev_wa, prev_wd;
  logic                  match, side_after, is_ins;

  assign match      = (rd_word == key_q);
  assign side_after = (cmd_q == ole_pkg::CMD_INS_TAIL) || (cmd_q == ole_pkg::CMD_INS_AFTER);
  assign is_ins     = (cmd_q == ole_pkg::CMD_INS_HEAD) || (cmd_q == ole_pkg::CMD_INS_TAIL) ||
                      (cmd_q == ole_pkg::CMD_INS_AFTER) || (cmd_q == ole_pkg::CMD_INS_BEFORE);

  always_comb begin
    case (ctl.op)
      ole_pkg::OP_SEEK:      rd_idx = head;
      ole_pkg::OP_WALK:      rd_idx = rd_next;
      ole_pkg::OP_ALLOC:     rd_idx = free_idx;
      ole_pkg::OP_UNLINK_RD: rd_idx = n_idx;
      default:               rd_idx = cur;
    endcase
  end

  // Memory write ports: one write per memory per cycle.
  always_comb begin
    word_we = 1'b0;
    word_wa = free_idx;
    next_we = 1'b0;
    next_wa = n_idx;
    next_wd = NIL;
    prev_we = 1'b0;
    prev_wa = n_idx;
    prev_wd = NIL;
    case (ctl.op)
      ole_pkg::OP_TAKE: begin
        word_we = 1'b1;
      end
      ole_pkg::OP_LINK1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        if (head == NIL) begin
          next_wd = NIL;
          prev_wd = NIL;
        end else if (side_after) begin
          next_wd = nb_idx;
          prev_wd = m_idx;
        end else begin
          next_wd = m_idx;
          prev_wd = nb_idx;
        end
      end
      ole_pkg::OP_LINK2: begin
        if (side_after) begin
          next_we = 1'b1;
          next_wa = m_idx;
          next_wd = n_idx;
          prev_we = (nb_idx != NIL);
          prev_wa = nb_idx;
          prev_wd = n_idx;
        end else begin
          prev_we = 1'b1;
          prev_wa = m_idx;
          prev_wd = n_idx;
          next_we = (nb_idx != NIL);
          next_wa = nb_idx;
          next_wd = n_idx;
        end
      end
      ole_pkg::OP_UNLINK1: begin
        next_we = (rd_prev != NIL);
        next_wa = rd_prev;
        next_wd = rd_next;
        prev_we = (rd_next != NIL);
        prev_wa = rd_next;
        prev_wd = rd_prev;
      end
      ole_pkg::OP_UNLINK2: begin
        next_we = 1'b1;
        next_wd = free_idx;
      end
      default: begin
        word_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_word <= word_mem[rd_idx[AW-1:0]];
    rd_next <= next_mem[rd_idx[AW-1:0]];
    rd_prev <= prev_mem[rd_idx[AW-1:0]];
    if (word_we) word_mem[word_wa[AW-1:0]] <= value_q;
    if (next_we) next_mem[next_wa[AW-1:0]] <= next_wd;
    if (prev_we) prev_mem[prev_wa[AW-1:0]] <= prev_wd;
  end

  always_comb begin
    cur_next   = cur;
    m_next     = m_idx;
    n_next     = n_idx;
    nb_next    = nb_idx;
    head_next  = head;
    tail_next  = tail;
    free_next  = free_idx;
    hwm_next   = hwm;
    count_next = elem_count;
    case (ctl.op)
      ole_pkg::OP_DISPATCH: begin
        case (cmd_q)
          ole_pkg::CMD_INS_HEAD: begin
            m_next  = head;
            nb_next = NIL;
          end
          ole_pkg::CMD_INS_TAIL: begin
            m_next  = tail;
            nb_next = NIL;
          end
          ole_pkg::CMD_DEL_HEAD: n_next = head;
          ole_pkg::CMD_DEL_TAIL: n_next = tail;
          default:               n_next = n_idx;
        endcase
      end
      ole_pkg::OP_SEEK: begin
        cur_next = head;
      end
      ole_pkg::OP_WALK: begin
        if (!match) begin
          cur_next = rd_next;
        end else if (is_ins) begin
          m_next  = cur;
          nb_next = side_after ? rd_next : rd_prev;
        end else begin
          n_next = (cmd_q == ole_pkg::CMD_DEL_AFTER) ? rd_next : rd_prev;
        end
      end
      ole_pkg::OP_TAKE: begin
        // Nodes at or above the high-water mark were never used, so their
        // free-list successor is simply the next index.
        n_next     = free_idx;
        count_next = elem_count + IW'(1);
        if (free_idx == hwm) begin
          free_next = free_idx + IW'(1);
          hwm_next  = hwm + IW'(1);
        end else begin
          free_next = rd_next;
        end
      end
      ole_pkg::OP_LINK1: begin
        if (head == NIL) begin
          head_next = n_idx;
          tail_next = n_idx;
        end
      end
      ole_pkg::OP_LINK2: begin
        if (nb_idx == NIL) begin
          if (side_after) tail_next = n_idx;
          else            head_next = n_idx;
        end
      end
      ole_pkg::OP_UNLINK1: begin
        if (rd_prev == NIL) head_next = rd_next;
        if (rd_next == NIL) tail_next = rd_prev;
      end
      ole_pkg::OP_UNLINK2: begin
        free_next = n_idx;
        if (elem_count != '0) count_next = elem_count - IW'(1);
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= NIL;
      tail       <= NIL;
      free_idx   <= '0;
      hwm        <= '0;
      elem_count <= '0;
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      free_idx   <= free_next;
      hwm        <= hwm_next;
      elem_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    m_idx  <= m_next;
    n_idx  <= n_next;
    nb_idx <= nb_next;
    if (ctl.op == ole_pkg::OP_CAPTURE) begin
      cmd_q   <= command;
      key_q   <= key[WORD_WIDTH-1:0];
      value_q <= value[WORD_WIDTH-1:0];
    end
  end

  assign sts.cmd      = cmd_q;
  assign sts.head_nil = (head == NIL);
  assign sts.free_nil = (free_idx == NIL);
  assign sts.match    = match;
  assign sts.next_nil = (rd_next == NIL);
  assign sts.prev_nil = (rd_prev == NIL);
  assign count        = 9'(elem_count);

  `OLE_ASSERT(a_ends_agree, clk, rst, (head == NIL) == (tail == NIL))
  `OLE_ASSERT(a_full_all_used, clk, rst, (free_idx == NIL) |-> (hwm == NIL))
  `OLE_ASSERT(a_count_bound, clk, rst, elem_count <= NIL)

endmodule

[rtl/ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded doubly linked list of words with a free list, one command per item.
// ----------------------------------------------------------------------------
// Steps: a refused command goes straight to the result from dispatch or walk;
// inserts run alloc, take, link1 and link2 (link2 is skipped on an empty list),
// deletes run unlink read, unlink1, unlink2; keyed commands seek and walk first.
// Throughput: one item at a time; a new item is taken in the result cycle.
// The key search visits one node per cycle through the link memory read port.
// Reset empties the list at once; no memory clearing pass is needed.

module ordered_list_engine #(
  parameter int CAPACITY   = 256,
  parameter int WORD_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        done,
  output logic [2:0]  status,
  output logic [8:0]  count
);

  ole_pkg::ctl_t ctl;
  ole_pkg::sts_t sts;

  ole_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .ctl    (ctl),
    .sts    (sts)
  );

  ole_dpath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sts     (sts),
    .command (command),
    .key     (key),
    .value   (value),
    .count   (count)
  );

endmodule
